[sv/fmp_pkg.sv]
// Shared types and constants for the Fibonacci matrix-power pipeline.
// No dependencies; used by fmp_step and fibonacci_by_matrix_power_top.
`default_nettype none

package fmp_pkg;

	// number of exponent bits the constant tables cover
	localparam int MAX_BITS = 7;

	// F(2^i) for i = 0 .. MAX_BITS-1 (the repeated squares of [[1,1],[1,0]])
	localparam logic [63:0] FIB_K [MAX_BITS] = '{
		64'd1, 64'd1, 64'd3, 64'd21, 64'd987, 64'd2178309, 64'd10610209857723
	};

	// F(2^i + 1) for i = 0 .. MAX_BITS-1
	localparam logic [63:0] FIB_K1 [MAX_BITS] = '{
		64'd1, 64'd2, 64'd5, 64'd34, 64'd1597, 64'd3524578, 64'd17167680177565
	};

	// per-item side information carried down the pipeline
	typedef struct packed {
		logic ovf;      // index past the largest fitting one
		logic direct;   // index 0, 1 or 2: answer without matrix work
		logic nonzero;  // index is not 0
	} side_t;

	// largest k with F(k) <= 2^(vw-1)-1, evaluated at elaboration
	function automatic int fit_limit(input int vw);
		logic [63:0] lim;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		int k;
		lim = (64'd1 << (vw - 1)) - 64'd1;
		a = 64'd1;
		b = 64'd1;
		k = 2;
		while (b <= lim - a) begin
			c = a + b;
			a = b;
			b = c;
			k = k + 1;
		end
		return k;
	endfunction

endpackage

`default_nettype wire

[sv/fibonacci_by_matrix_power_top.sv]
// Top level of the Fibonacci matrix-power pipeline.
// Depends on fmp_pkg and fmp_step.
//
// Usage:
//   Input channel in_valid / in_ready carries index (n). Output channel
//   out_valid / out_ready carries fib_value = F(n) and overflow. A transfer
//   happens on a rising edge with valid and ready both high.
//   n = 1 or 2 gives 1, n = 0 gives 0. When F(n) does not fit in a signed
//   VALUE_WIDTH-bit word (n > 92 at 64 bits), overflow is 1 and fib_value 0.
//   There is one input register, two register levels per exponent bit
//   (partial products, then recombination of the Fibonacci pair), and one
//   output register.
//   Throughput is one item per cycle while out_ready is high; each exponent
//   bit has its own four split multipliers by the constant power of that bit.
//   Every level has its own valid bit and moves when the level after it is
//   empty or moving, so bubbles close up and a stalled receiver only holds
//   the items behind the waiting result until the pipeline is full.
//   Reset clears all valid bits; no item is in flight afterwards.
`default_nettype none

module fibonacci_by_matrix_power_top #(
	parameter int VALUE_WIDTH = 64,
	parameter int INDEX_WIDTH = 7
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [INDEX_WIDTH-1:0] index,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [62:0]                 fib_value,
	output logic                        overflow
);

	localparam int LIMIT = fmp_pkg::fit_limit(VALUE_WIDTH);

	// chain between stages; element 0 is the input register
	logic                   v_c [INDEX_WIDTH+1];
	logic                   r_c [INDEX_WIDTH+1];
	logic [VALUE_WIDTH-1:0] f0_c [INDEX_WIDTH+1];
	logic [VALUE_WIDTH-1:0] f1_c [INDEX_WIDTH+1];
	logic [INDEX_WIDTH-1:0] exp_c [INDEX_WIDTH+1];
	fmp_pkg::side_t         side_c [INDEX_WIDTH+1];

	logic                   v_s0;
	logic [INDEX_WIDTH-1:0] exp_s0;
	fmp_pkg::side_t         side_s0;

	logic                   out_valid_q;
	logic [62:0]            fib_value_q;
	logic                   overflow_q;

	logic                   out_stage_ready;
	logic [VALUE_WIDTH-1:0] sum;
	logic [63:0]            sum_wide;

	// input register: classify the index and form the exponent n-2
	assign in_ready = !v_s0 || r_c[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (r_c[0] || !v_s0) begin
			v_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			exp_s0          <= index - INDEX_WIDTH'(2);
			side_s0.ovf     <= 32'(index) > LIMIT;
			side_s0.direct  <= index <= INDEX_WIDTH'(2);
			side_s0.nonzero <= index != '0;
		end
	end

	// start from the identity: pair (F(0), F(1))
	assign v_c[0]    = v_s0;
	assign f0_c[0]   = '0;
	assign f1_c[0]   = VALUE_WIDTH'(1);
	assign exp_c[0]  = exp_s0;
	assign side_c[0] = side_s0;

	// one step per exponent bit, least significant first
	for (genvar g = 0; g < INDEX_WIDTH; g++) begin : g_bit
		fmp_step #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.INDEX_WIDTH(INDEX_WIDTH),
			.BIT_POS(g)
		) u_step (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(v_c[g]),
			.in_ready(r_c[g]),
			.in_f0(f0_c[g]),
			.in_f1(f1_c[g]),
			.in_exp(exp_c[g]),
			.in_side(side_c[g]),
			.out_valid(v_c[g+1]),
			.out_ready(r_c[g+1]),
			.out_f0(f0_c[g+1]),
			.out_f1(f1_c[g+1]),
			.out_exp(exp_c[g+1]),
			.out_side(side_c[g+1])
		);
	end

	// output register: F(k) + F(k+1) = F(n), or the special answers
	assign out_stage_ready = !out_valid_q || out_ready;
	assign r_c[INDEX_WIDTH] = out_stage_ready;

	assign sum      = f0_c[INDEX_WIDTH] + f1_c[INDEX_WIDTH];
	assign sum_wide = 64'(sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_stage_ready) begin
			out_valid_q <= v_c[INDEX_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (v_c[INDEX_WIDTH] && out_stage_ready) begin
			if (side_c[INDEX_WIDTH].ovf) begin
				fib_value_q <= '0;
				overflow_q  <= 1'b1;
			end else if (side_c[INDEX_WIDTH].direct) begin
				fib_value_q <= 63'(side_c[INDEX_WIDTH].nonzero);
				overflow_q  <= 1'b0;
			end else begin
				fib_value_q <= sum_wide[62:0];
				overflow_q  <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign fib_value = fib_value_q;
	assign overflow  = overflow_q;

endmodule

`default_nettype wire

[sv/fmp_step.sv]
// One exponent bit of the matrix power: conditional multiply of the
// Fibonacci pair (F(k), F(k+1)) by the constant power for this bit.
// Two register levels: partial products, then recombination. Uses fmp_pkg.
`default_nettype none

module fmp_step #(
	parameter int VALUE_WIDTH = 64,
	parameter int INDEX_WIDTH = 7,
	parameter int BIT_POS = 0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [VALUE_WIDTH-1:0] in_f0,
	input  wire logic [VALUE_WIDTH-1:0] in_f1,
	input  wire logic [INDEX_WIDTH-1:0] in_exp,
	input  wire fmp_pkg::side_t         in_side,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [VALUE_WIDTH-1:0]      out_f0,
	output logic [VALUE_WIDTH-1:0]      out_f1,
	output logic [INDEX_WIDTH-1:0]      out_exp,
	output fmp_pkg::side_t              out_side
);

	// low half is the wider one, so the dropped high x high term lands at or above the word
	localparam int LO = (VALUE_WIDTH + 1) / 2;
	localparam int HI = VALUE_WIDTH - LO;

	// constant power for this bit, reduced to the datapath width
	localparam logic [63:0] RAW_B   = fmp_pkg::FIB_K[BIT_POS];
	localparam logic [63:0] RAW_B1  = fmp_pkg::FIB_K1[BIT_POS];
	localparam logic [63:0] RAW_BM1 = RAW_B1 - RAW_B;
	localparam logic [VALUE_WIDTH-1:0] CB   = RAW_B[VALUE_WIDTH-1:0];
	localparam logic [VALUE_WIDTH-1:0] CB1  = RAW_B1[VALUE_WIDTH-1:0];
	localparam logic [VALUE_WIDTH-1:0] CBM1 = RAW_BM1[VALUE_WIDTH-1:0];

	// products: A1*Fb, A0*F(b-1), A1*F(b+1), A0*Fb
	localparam logic [VALUE_WIDTH-1:0] CMUL [4] = '{CB, CBM1, CB1, CB};

	logic [VALUE_WIDTH-1:0] xmul [4];
	logic [2*LO-1:0]        pl [4];
	logic [HI-1:0]          pc [4];
	logic [VALUE_WIDTH-1:0] prod [4];

	logic                   v_s1;
	logic                   mul_s1;
	logic [VALUE_WIDTH-1:0] f0_s1;
	logic [VALUE_WIDTH-1:0] f1_s1;
	logic [2*LO-1:0]        pl_s1 [4];
	logic [HI-1:0]          pc_s1 [4];
	logic [INDEX_WIDTH-1:0] exp_s1;
	fmp_pkg::side_t         side_s1;

	logic                   v_s2;
	logic [VALUE_WIDTH-1:0] f0_s2;
	logic [VALUE_WIDTH-1:0] f1_s2;
	logic [INDEX_WIDTH-1:0] exp_s2;
	fmp_pkg::side_t         side_s2;

	logic ready_s1;

	// per-level flow control: a level moves when the next one is free or moving
	assign ready_s1 = !v_s2 || out_ready;
	assign in_ready = !v_s1 || ready_s1;

	assign xmul[0] = in_f1;
	assign xmul[1] = in_f0;
	assign xmul[2] = in_f1;
	assign xmul[3] = in_f0;

	// split multiplies: low x low, and the two cross terms mod 2^HI
	for (genvar j = 0; j < 4; j++) begin : g_mul
		localparam logic [LO-1:0] C_LO = CMUL[j][LO-1:0];
		localparam logic [HI-1:0] C_HI = CMUL[j][VALUE_WIDTH-1:LO];
		assign pl[j] = (2*LO)'(xmul[j][LO-1:0]) * (2*LO)'(C_LO);
		assign pc[j] = HI'(xmul[j][LO-1:0]) * C_HI
			+ xmul[j][VALUE_WIDTH-1:LO] * HI'(C_LO);
		assign prod[j] = VALUE_WIDTH'(pl_s1[j]) + {pc_s1[j], {LO{1'b0}}};
	end

	// level one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1 || !v_s1) begin
			v_s1 <= in_valid;
		end
	end

	// level one payload: partial products or bypass
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mul_s1  <= in_exp[BIT_POS];
			f0_s1   <= in_f0;
			f1_s1   <= in_f1;
			pl_s1   <= pl;
			pc_s1   <= pc;
			exp_s1  <= in_exp;
			side_s1 <= in_side;
		end
	end

	// level two valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (out_ready || !v_s2) begin
			v_s2 <= v_s1;
		end
	end

	// level two payload: recombine into the new pair
	always_ff @(posedge clk) begin
		if (v_s1 && ready_s1) begin
			if (mul_s1) begin
				f0_s2 <= prod[0] + prod[1];
				f1_s2 <= prod[2] + prod[3];
			end else begin
				f0_s2 <= f0_s1;
				f1_s2 <= f1_s1;
			end
			exp_s2  <= exp_s1;
			side_s2 <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_f0    = f0_s2;
	assign out_f1    = f1_s2;
	assign out_exp   = exp_s2;
	assign out_side  = side_s2;

endmodule

`default_nettype wire
